// ===== sv/hcr_pkg.sv =====
// Package: shared constants, register map and types of the height colour ramp
`timescale 1ns / 1ps
package hcr_pkg;

   // colour layout
   localparam int CHAN_BITS = 8;
   localparam int NUM_CHAN  = 3;
   localparam int RGB_BITS  = CHAN_BITS * NUM_CHAN;
   localparam int CHAN_LEVELS = 256;

   // one divider step per quotient bit; the quotient never reaches CHAN_LEVELS
   localparam int DIV_STEPS = $clog2(CHAN_LEVELS);

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_MID  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_HIGH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEIGHT_MIN = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEIGHT_MID = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEIGHT_MAX = 3'd5;

   localparam logic [RGB_BITS-1:0] COLOR_LOW_RESET  = 24'h000000;
   localparam logic [RGB_BITS-1:0] COLOR_MID_RESET  = 24'h000000;
   localparam logic [RGB_BITS-1:0] COLOR_HIGH_RESET = 24'hFFFFFF;
   localparam logic [RGB_BITS-1:0] COLOR_BLACK      = 24'h000000;

   // per-item control that travels beside the divider
   typedef struct packed {
      logic                interp;
      logic [RGB_BITS-1:0] fixed_rgb;
   } hcr_ctrl_type;

endpackage

// ===== sv/hcr_if.sv =====
// Interfaces: height request channel and colour response channel
`timescale 1ns / 1ps
interface hcr_req_if #(parameter int HEIGHT_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [HEIGHT_BITS-1:0] height;

   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

interface hcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] rgb;

   modport source (output valid, output rgb, input ready);
   modport sink   (input valid, input rgb, output ready);
endinterface

// ===== sv/height_color_ramp_top.sv =====
// Top level: register file and pipeline of the three-point height colour ramp
//
//  port     dir   handshake        beat payload
//  req      in    valid / ready    height, signed HEIGHT_BITS
//  rsp      out   valid / ready    rgb, 24 bits (red 23:16, blue 7:0)
//  csr_*    in    APB write/read   colour and height registers at 4*index
//
//  One beat is taken every cycle while the response is not stalled; a result
//  passes through two stages of compare and select, one multiply stage, eight
//  divider stages (one quotient bit each) and the output register.
//  A stalled response freezes every stage together; nothing is dropped.
//  Reset (synchronous) clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
module height_color_ramp_top
   import hcr_pkg::*;
#(
   parameter int HEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   hcr_req_if.sink                  req,
   hcr_rsp_if.source                rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int HB    = HEIGHT_BITS;
   localparam int NUM_W = HEIGHT_BITS + CHAN_BITS;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   logic [RGB_BITS-1:0]  color_low_ff, color_mid_ff, color_high_ff;
   logic signed [HB-1:0] height_min_ff, height_mid_ff, height_max_ff;
   logic                 csr_wr;
   logic [CSR_IDX_BITS-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_IDX_BITS+1:2];

   // write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         color_low_ff  <= COLOR_LOW_RESET;
         color_mid_ff  <= COLOR_MID_RESET;
         color_high_ff <= COLOR_HIGH_RESET;
         height_min_ff <= '0;
         height_mid_ff <= '0;
         height_max_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_COLOR_LOW:  color_low_ff  <= csr_pwdata[RGB_BITS-1:0];
            REG_COLOR_MID:  color_mid_ff  <= csr_pwdata[RGB_BITS-1:0];
            REG_COLOR_HIGH: color_high_ff <= csr_pwdata[RGB_BITS-1:0];
            REG_HEIGHT_MIN: height_min_ff <= csr_pwdata[HB-1:0];
            REG_HEIGHT_MID: height_mid_ff <= csr_pwdata[HB-1:0];
            REG_HEIGHT_MAX: height_max_ff <= csr_pwdata[HB-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         REG_COLOR_LOW:  csr_prdata = CSR_DATA_BITS'(color_low_ff);
         REG_COLOR_MID:  csr_prdata = CSR_DATA_BITS'(color_mid_ff);
         REG_COLOR_HIGH: csr_prdata = CSR_DATA_BITS'(color_high_ff);
         REG_HEIGHT_MIN: csr_prdata = CSR_DATA_BITS'(height_min_ff);
         REG_HEIGHT_MID: csr_prdata = CSR_DATA_BITS'(height_mid_ff);
         REG_HEIGHT_MAX: csr_prdata = CSR_DATA_BITS'(height_max_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline control: every stage moves when the output slot frees up
   // ------------------------------------------------------------------
   logic adv;
   logic v_s1_ff, v_s2_ff, v_s3_ff, v_out_ff;
   logic [DIV_STEPS-1:0] v_div_ff;

   assign adv       = ~v_out_ff | rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s1_ff  <= 1'b0;
         v_s2_ff  <= 1'b0;
         v_s3_ff  <= 1'b0;
         v_div_ff <= '0;
         v_out_ff <= 1'b0;
      end else if (adv) begin
         v_s1_ff  <= req.valid;
         v_s2_ff  <= v_s1_ff;
         v_s3_ff  <= v_s2_ff;
         v_div_ff <= {v_div_ff[DIV_STEPS-2:0], v_s3_ff};
         v_out_ff <= v_div_ff[DIV_STEPS-1];
      end
   end

   // ------------------------------------------------------------------
   // stage 1: compare the height with the three break points
   // ------------------------------------------------------------------
   logic signed [HB-1:0] z;
   logic lt_min_in, gt_max_in, le_mid_in, le_min_in, ge_mid_in, ge_max_in;
   logic [HB-1:0] dmin_in, dmid_in;
   logic lt_min_ff, gt_max_ff, le_mid_ff, le_min_ff, ge_mid_ff, ge_max_ff;
   logic [HB-1:0] dmin_ff, dmid_ff;

   assign z = req.height;

   always_comb begin
      lt_min_in = (z <  height_min_ff);
      gt_max_in = (z >  height_max_ff);
      le_mid_in = (z <= height_mid_ff);
      le_min_in = (z <= height_min_ff);
      ge_mid_in = (z >= height_mid_ff);
      ge_max_in = (z >= height_max_ff);
      dmin_in   = z - height_min_ff;
      dmid_in   = z - height_mid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lt_min_ff <= lt_min_in;
         gt_max_ff <= gt_max_in;
         le_mid_ff <= le_mid_in;
         le_min_ff <= le_min_in;
         ge_mid_ff <= ge_mid_in;
         ge_max_ff <= ge_max_in;
         dmin_ff   <= dmin_in;
         dmid_ff   <= dmid_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: choose the segment, clamp or set up the interpolation
   // ------------------------------------------------------------------
   hcr_ctrl_type         ctrl_s2_in;
   logic [RGB_BITS-1:0]  ca, cb;
   logic [HB-1:0]        d_s2_in, span_s2_in;
   logic [CHAN_BITS-1:0] a_s2_in [NUM_CHAN];
   logic [CHAN_BITS-1:0] m_s2_in [NUM_CHAN];
   logic                 neg_s2_in [NUM_CHAN];

   hcr_ctrl_type         ctrl_s2_ff;
   logic [HB-1:0]        d_s2_ff, span_s2_ff;
   logic [CHAN_BITS-1:0] a_s2_ff [NUM_CHAN];
   logic [CHAN_BITS-1:0] m_s2_ff [NUM_CHAN];
   logic                 neg_s2_ff [NUM_CHAN];

   always_comb begin
      ctrl_s2_in.interp    = 1'b0;
      ctrl_s2_in.fixed_rgb = COLOR_BLACK;
      ca         = color_mid_ff;
      cb         = color_high_ff;
      d_s2_in    = dmid_ff;
      span_s2_in = height_max_ff - height_mid_ff;
      if (lt_min_ff || gt_max_ff) begin
         // out of range: black
         ctrl_s2_in.fixed_rgb = COLOR_BLACK;
      end else if (le_mid_ff) begin
         ca         = color_low_ff;
         cb         = color_mid_ff;
         d_s2_in    = dmin_ff;
         span_s2_in = height_mid_ff - height_min_ff;
         if (le_min_ff) begin
            ctrl_s2_in.fixed_rgb = color_low_ff;
         end else if (ge_mid_ff) begin
            ctrl_s2_in.fixed_rgb = color_mid_ff;
         end else begin
            ctrl_s2_in.interp = 1'b1;
         end
      end else begin
         if (ge_max_ff) begin
            ctrl_s2_in.fixed_rgb = color_high_ff;
         end else begin
            ctrl_s2_in.interp = 1'b1;
         end
      end
   end

   // per channel: lower end, distance to the upper end and its direction
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         a_s2_in[c]   = ca[c*CHAN_BITS +: CHAN_BITS];
         neg_s2_in[c] = (cb[c*CHAN_BITS +: CHAN_BITS] < ca[c*CHAN_BITS +: CHAN_BITS]);
         m_s2_in[c]   = neg_s2_in[c]
                      ? (ca[c*CHAN_BITS +: CHAN_BITS] - cb[c*CHAN_BITS +: CHAN_BITS])
                      : (cb[c*CHAN_BITS +: CHAN_BITS] - ca[c*CHAN_BITS +: CHAN_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_s2_ff <= ctrl_s2_in;
         d_s2_ff    <= d_s2_in;
         span_s2_ff <= span_s2_in;
         a_s2_ff    <= a_s2_in;
         m_s2_ff    <= m_s2_in;
         neg_s2_ff  <= neg_s2_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: scale the distance by each channel step
   // ------------------------------------------------------------------
   logic [NUM_W-1:0]     num_s3_in [NUM_CHAN];
   hcr_ctrl_type         ctrl_s3_ff;
   logic [HB-1:0]        span_s3_ff;
   logic [NUM_W-1:0]     num_s3_ff [NUM_CHAN];
   logic [CHAN_BITS-1:0] a_s3_ff [NUM_CHAN];
   logic                 neg_s3_ff [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_s3_in[c] = NUM_W'(d_s2_ff) * NUM_W'(m_s2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_s3_ff <= ctrl_s2_ff;
         span_s3_ff <= span_s2_ff;
         num_s3_ff  <= num_s3_in;
         a_s3_ff    <= a_s2_ff;
         neg_s3_ff  <= neg_s2_ff;
      end
   end

   // ------------------------------------------------------------------
   // stages 4 to 11: divide by the segment span
   // ------------------------------------------------------------------
   logic [CHAN_BITS-1:0] chan_div [NUM_CHAN];
   hcr_ctrl_type         ctrl_div_ff [DIV_STEPS];

   genvar g;
   generate
      for (g = 0; g < NUM_CHAN; g++) begin : g_chan
         hcr_divider #(
            .HEIGHT_BITS (HEIGHT_BITS)
         ) u_div (
            .clock (clock),
            .adv   (adv),
            .num   (num_s3_ff[g]),
            .den   (span_s3_ff),
            .base  (a_s3_ff[g]),
            .neg   (neg_s3_ff[g]),
            .chan  (chan_div[g])
         );
      end
   endgenerate

   // carry the control beside the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_div_ff[0] <= ctrl_s3_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            ctrl_div_ff[k] <= ctrl_div_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic [RGB_BITS-1:0] rgb_out_in, rgb_out_ff;

   always_comb begin
      if (ctrl_div_ff[DIV_STEPS-1].interp) begin
         rgb_out_in = {chan_div[2], chan_div[1], chan_div[0]};
      end else begin
         rgb_out_in = ctrl_div_ff[DIV_STEPS-1].fixed_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rgb_out_ff <= rgb_out_in;
      end
   end

   assign rsp.valid = v_out_ff;
   assign rsp.rgb   = rgb_out_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_s1_ff)
      else $error("accepted request beat did not enter stage 1");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> ($stable(v_div_ff) && $stable(v_s3_ff) && rsp.valid))
      else $error("pipeline moved while the response was stalled");

   a_span_positive: assert property (@(posedge clock) disable iff (reset)
      (v_s2_ff && ctrl_s2_ff.interp) |-> (span_s2_ff >= HB'(2)))
      else $error("interpolation set up with a span below two");

endmodule

// ===== sv/hcr_divider.sv =====
// Pipelined restoring divider for one colour channel, one quotient bit a stage
`timescale 1ns / 1ps
module hcr_divider
   import hcr_pkg::*;
#(
   parameter int HEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [HEIGHT_BITS+CHAN_BITS-1:0]  num,
   input  logic [HEIGHT_BITS-1:0]            den,
   input  logic [CHAN_BITS-1:0]              base,
   input  logic                              neg,
   output logic [CHAN_BITS-1:0]              chan
);

   localparam int HB = HEIGHT_BITS;

   logic [HB-1:0]        rem_ff  [DIV_STEPS];
   logic [CHAN_BITS-1:0] low_ff  [DIV_STEPS];
   logic [CHAN_BITS-1:0] q_ff    [DIV_STEPS];
   logic [HB-1:0]        den_ff  [DIV_STEPS];
   logic [CHAN_BITS-1:0] base_ff [DIV_STEPS];
   logic                 neg_ff  [DIV_STEPS];

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_step
         logic [HB-1:0]        rem_src;
         logic [CHAN_BITS-1:0] low_src;
         logic [CHAN_BITS-1:0] q_src;
         logic [HB-1:0]        den_src;
         logic [CHAN_BITS-1:0] base_src;
         logic                 neg_src;
         logic [HB:0]          trial;
         logic [HB:0]          diff;
         logic                 take;
         logic [HB-1:0]        rem_in;
         logic [CHAN_BITS-1:0] low_in;
         logic [CHAN_BITS-1:0] q_in;

         // pick up the partial result of the previous step
         if (k == 0) begin : g_first
            always_comb begin
               rem_src  = num[HB+CHAN_BITS-1:CHAN_BITS];
               low_src  = num[CHAN_BITS-1:0];
               q_src    = '0;
               den_src  = den;
               base_src = base;
               neg_src  = neg;
            end
         end else begin : g_next
            always_comb begin
               rem_src  = rem_ff[k-1];
               low_src  = low_ff[k-1];
               q_src    = q_ff[k-1];
               den_src  = den_ff[k-1];
               base_src = base_ff[k-1];
               neg_src  = neg_ff[k-1];
            end
         end

         // shift in the next numerator bit, subtract where it fits
         always_comb begin
            trial  = {rem_src, low_src[CHAN_BITS-1]};
            diff   = trial - {1'b0, den_src};
            take   = (trial >= {1'b0, den_src});
            rem_in = take ? diff[HB-1:0] : trial[HB-1:0];
            low_in = {low_src[CHAN_BITS-2:0], 1'b0};
            q_in   = {q_src[CHAN_BITS-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k]  <= rem_in;
               low_ff[k]  <= low_in;
               q_ff[k]    <= q_in;
               den_ff[k]  <= den_src;
               base_ff[k] <= base_src;
               neg_ff[k]  <= neg_src;
            end
         end
      end
   endgenerate

   // step from the lower end's channel towards the upper one
   assign chan = neg_ff[DIV_STEPS-1] ? (base_ff[DIV_STEPS-1] - q_ff[DIV_STEPS-1])
                                     : (base_ff[DIV_STEPS-1] + q_ff[DIV_STEPS-1]);

endmodule
